// ===== src/bclt_pkg.sv =====
// Shared types, character codes and helpers for the bracket config text lexer.
// No dependencies; imported by every module of the block.
package bclt_pkg;

    localparam int DEF_COUNT_BITS = 16;
    localparam int Q_DEPTH        = 4;
    localparam int Q_PTR_BITS     = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS     = $clog2(Q_DEPTH + 1);
    localparam int N_SLOTS        = 3;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_LSQ   = 8'h5B;
    localparam logic [7:0] CH_RSQ   = 8'h5D;
    localparam logic [7:0] CH_US    = 8'h5F;

    typedef enum logic [2:0] {
        KIND_LSQ   = 3'd0,
        KIND_RSQ   = 3'd1,
        KIND_COMMA = 3'd2,
        KIND_STR   = 3'd3,
        KIND_IDENT = 3'd4,
        KIND_INT   = 3'd5,
        KIND_END   = 3'd6,
        KIND_ERR   = 3'd7
    } t_kind;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_INT   = 4'b0010,
        MODE_IDENT = 4'b0100,
        MODE_STR   = 4'b1000
    } t_mode;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic [15:0] col;
        logic [7:0]  bad;
        logic        done;
    } t_result;

    // slot 0: flushed pending token, slot 1: immediate token, error or
    // final flush, slot 2: end token
    typedef struct packed {
        logic [N_SLOTS-1:0] mask;
        t_result [N_SLOTS-1:0] slot;
    } t_bundle;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A))
               || (b == CH_US);
    endfunction

endpackage

// ===== src/bracket_config_text_lexer_unit.sv =====
// Top level of the bracket config text lexer: front end, bundle queue, back end.
// Depends on bclt_pkg, bclt_front, bclt_queue and bclt_back.
//
// Input stream: one text byte per word on s_axis_tdata, s_axis_tlast marks the
// final byte of a text. Output stream: one token per word; token kind on
// m_axis_tuser, m_axis_tlast set on the end token or the error token.
// Each byte is classified in the cycle it is taken; its results (up to three:
// a finished pending token, a punctuation or error token, and the end token on
// the final byte) go into a four-entry bundle queue as one entry.
// With the queue empty, the results of a byte are written into the queue at the
// edge that takes the byte, and the first is then loaded into the output register.
// Throughput: one byte per cycle while each byte yields at most one result and
// the receiver keeps up; a byte with several results sends them in turn from the
// output register, and the queue absorbs such bursts until it fills, then
// s_axis_tready drops. A stalled receiver keeps the output word steady; the
// front keeps taking bytes until the queue is full.
// Reset (synchronous, active low) clears lexer state, the queue and the output
// valid. The final byte of each text also returns the lexer to its reset state.
module bracket_config_text_lexer_unit
    import bclt_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // data_byte
    input  logic        s_axis_tlast,  // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // start_offset, token_length, line_number,
                                       // column_number, bad_byte
    output logic [2:0]  m_axis_tuser,  // token_kind
    output logic        m_axis_tlast   // stream_done
);

    logic    accept;
    logic    push;
    logic    pop;
    t_bundle push_bundle;
    t_bundle head;
    t_qstat  qstat;
    t_result result;

    assign s_axis_tready = !qstat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    bclt_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_push   (push),
        .o_bundle (push_bundle)
    );

    bclt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (push_bundle),
        .i_pop    (pop),
        .o_head   (head),
        .o_stat   (qstat)
    );

    bclt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_stat   (qstat),
        .o_pop    (pop),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_result (result)
    );

    assign m_axis_tdata = {result.bad, result.col, result.line, result.len, result.start};
    assign m_axis_tuser = result.kind;
    assign m_axis_tlast = result.done;

endmodule

// ===== src/bclt_front.sv =====
// Front end: accepts text bytes, tracks lexer state and positions, and builds
// a bundle of up to three results per byte. Depends on bclt_pkg.
module bclt_front
    import bclt_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output logic       o_push,
    output t_bundle    o_bundle
);

    localparam int CW = COUNT_BITS;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] to16(input logic [CW-1:0] v);
        logic [CW+15:0] e;
        e = {16'b0, v};
        return e[15:0];
    endfunction

    function automatic t_result mk(input t_kind k, input logic [CW-1:0] st,
                                   input logic [CW-1:0] ln, input logic [CW-1:0] li,
                                   input logic [CW-1:0] co, input logic [7:0] bd,
                                   input logic dn);
        t_result r;
        r.kind  = k;
        r.start = to16(st);
        r.len   = to16(ln);
        r.line  = to16(li);
        r.col   = to16(co);
        r.bad   = bd;
        r.done  = dn;
        return r;
    endfunction

    function automatic t_kind mode_kind(input t_mode m);
        case (m)
            MODE_INT:   return KIND_INT;
            MODE_IDENT: return KIND_IDENT;
            default:    return KIND_STR;
        endcase
    endfunction

    t_mode          r_mode, n_mode;
    logic [CW-1:0]  r_pos, n_pos;
    logic [CW-1:0]  r_pstart, n_pstart;
    logic [CW-1:0]  r_plen, n_plen;
    logic [CW-1:0]  r_pline, n_pline;
    logic [CW-1:0]  r_pcol, n_pcol;
    logic [CW-1:0]  r_line, n_line;
    logic [CW-1:0]  r_col, n_col;
    logic           r_err, n_err;

    logic    consumed;
    logic    newline;
    logic    is_err;
    logic    digit;
    logic    alpha;
    t_bundle bundle;

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_pstart = r_pstart;
        n_plen   = r_plen;
        n_pline  = r_pline;
        n_pcol   = r_pcol;
        n_line   = r_line;
        n_col    = r_col;
        n_err    = r_err;
        consumed = 1'b0;
        newline  = 1'b0;
        is_err   = 1'b0;
        digit    = is_digit(i_byte);
        alpha    = is_alpha(i_byte);
        bundle   = '0;

        if (!r_err) begin
            case (r_mode)
                MODE_STR: begin
                    consumed = 1'b1;
                    if (i_byte == CH_QUOTE) begin
                        bundle.mask[0] = 1'b1;
                        n_mode         = MODE_IDLE;
                    end else begin
                        n_plen = sat_inc(r_plen);
                    end
                end
                MODE_INT: begin
                    if (digit) begin
                        consumed = 1'b1;
                        n_plen   = sat_inc(r_plen);
                    end else begin
                        bundle.mask[0] = 1'b1;
                        n_mode         = MODE_IDLE;
                    end
                end
                MODE_IDENT: begin
                    if (digit || alpha) begin
                        consumed = 1'b1;
                        n_plen   = sat_inc(r_plen);
                    end else begin
                        bundle.mask[0] = 1'b1;
                        n_mode         = MODE_IDLE;
                    end
                end
                default: ;
            endcase
            bundle.slot[0] = mk(mode_kind(r_mode), r_pstart, r_plen, r_pline, r_pcol,
                                8'h00, 1'b0);

            if (!consumed) begin
                if (digit || alpha || (i_byte == CH_QUOTE)) begin
                    n_mode   = digit ? MODE_INT : (alpha ? MODE_IDENT : MODE_STR);
                    n_pstart = digit || alpha ? r_pos : sat_inc(r_pos);
                    n_plen   = digit || alpha ? CW'(1) : CW'(0);
                    n_pline  = r_line;
                    n_pcol   = r_col;
                end else if ((i_byte == CH_LSQ) || (i_byte == CH_RSQ) ||
                             (i_byte == CH_COMMA)) begin
                    bundle.mask[1] = 1'b1;
                    bundle.slot[1] = mk((i_byte == CH_LSQ) ? KIND_LSQ :
                                        (i_byte == CH_RSQ) ? KIND_RSQ : KIND_COMMA,
                                        r_pos, CW'(1), r_line, r_col, 8'h00, 1'b0);
                end else if ((i_byte == CH_SP) || (i_byte == CH_TAB) ||
                             (i_byte == CH_CR)) begin
                    // separator only
                end else if (i_byte == CH_LF) begin
                    newline = 1'b1;
                end else begin
                    is_err         = 1'b1;
                    bundle.mask[1] = 1'b1;
                    bundle.slot[1] = mk(KIND_ERR, r_pos, CW'(1), r_line, r_col,
                                        i_byte, 1'b1);
                    n_err          = 1'b1;
                    n_mode         = MODE_IDLE;
                end
            end

            if (!is_err) begin
                n_pos = sat_inc(r_pos);
                if (newline) begin
                    n_line = sat_inc(r_line);
                    n_col  = CW'(1);
                end else begin
                    n_col = sat_inc(r_col);
                end
                if (i_last) begin
                    // a token still open at the final byte is flushed before END
                    if (n_mode != MODE_IDLE) begin
                        bundle.mask[1] = 1'b1;
                        bundle.slot[1] = mk(mode_kind(n_mode), n_pstart, n_plen,
                                            n_pline, n_pcol, 8'h00, 1'b0);
                    end
                    bundle.mask[2] = 1'b1;
                    bundle.slot[2] = mk(KIND_END, n_pos, CW'(0), n_line, r_col,
                                        8'h00, 1'b1);
                end
            end
        end
    end

    assign o_push   = i_accept && (bundle.mask != '0);
    assign o_bundle = bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_mode   <= MODE_IDLE;
            r_pos    <= '0;
            r_pstart <= '0;
            r_plen   <= '0;
            r_pline  <= CW'(1);
            r_pcol   <= CW'(1);
            r_line   <= CW'(1);
            r_col    <= CW'(1);
            r_err    <= 1'b0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_pstart <= n_pstart;
            r_plen   <= n_plen;
            r_pline  <= n_pline;
            r_pcol   <= n_pcol;
            r_line   <= n_line;
            r_col    <= n_col;
            r_err    <= n_err;
        end
    end

endmodule

// ===== src/bclt_queue.sv =====
// Short bundle queue between the front end and the result sequencer.
// Depends on bclt_pkg.
module bclt_queue
    import bclt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    input  logic    i_pop,
    output t_bundle o_head,
    output t_qstat  o_stat
);

    t_bundle                r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0]  r_wr_ptr;
    logic [Q_PTR_BITS-1:0]  r_rd_ptr;
    logic [Q_CNT_BITS-1:0]  r_count;

    assign o_stat.full  = (r_count == Q_CNT_BITS'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/bclt_back.sv =====
// Back end: walks the valid slots of the head bundle in order and drives the
// registered result stream. Depends on bclt_pkg.
module bclt_back
    import bclt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_bundle i_head,
    input  t_qstat  i_stat,
    output logic    o_pop,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_result
);

    logic [1:0]         r_slot;
    logic               r_valid;
    t_result            r_out;
    logic [N_SLOTS-1:0] avail;
    logic [1:0]         pick;
    logic               more;
    logic               load;

    always_comb begin
        for (int i = 0; i < N_SLOTS; i++) begin
            avail[i] = i_head.mask[i] && (2'(i) >= r_slot);
        end
        if (avail[0]) begin
            pick = 2'd0;
        end else if (avail[1]) begin
            pick = 2'd1;
        end else begin
            pick = 2'd2;
        end
        case (pick)
            2'd0:    more = avail[1] || avail[2];
            2'd1:    more = avail[2];
            default: more = 1'b0;
        endcase
    end

    assign load     = !i_stat.empty && (!r_valid || i_ready);
    assign o_pop    = load && !more;
    assign o_valid  = r_valid;
    assign o_result = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= i_head.slot[pick];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_slot  <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_slot  <= more ? pick + 2'd1 : 2'd0;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// ===== src/bclt_checker.sv =====
// Port-level checks for the bracket config text lexer, bound to the top level.
// Depends on bclt_pkg and bracket_config_text_lexer_unit.
module bclt_checker
    import bclt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed under stall");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tlast == ((m_axis_tuser == KIND_END) || (m_axis_tuser == KIND_ERR))))
        else $error("tlast does not match end or error kind");

    a_end_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_END) |->
            (m_axis_tdata[31:16] == 16'h0000) && (m_axis_tdata[71:64] == 8'h00))
        else $error("end token with nonzero length or byte");

endmodule

bind bracket_config_text_lexer_unit bclt_checker u_bclt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/lexer_token_checker.sv =====
// Token checker for the bracket config text lexer: watches both streams, predicts
// the token words for every accepted byte and compares them in order.
// Depends on bclt_pkg for the token kinds, lexer modes, result struct and char codes.
`timescale 1ns / 1ps

module lexer_token_checker
    import bclt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_byte_valid,
    input  logic        i_byte_ready,
    input  logic [7:0]  i_byte_data,    // data_byte
    input  logic        i_byte_last,    // final_byte
    input  logic        i_token_valid,
    input  logic        i_token_ready,
    input  logic [71:0] i_token_data,   // start_offset, token_length, line_number,
                                        // column_number, bad_byte
    input  logic [2:0]  i_token_user,   // token_kind
    input  logic        i_token_last,   // stream_done
    output int          o_fail_count,
    output int          o_tokens_owed
);

    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    // lexer state as seen by the predictor
    t_mode       scan_state;
    logic [15:0] offset_ctr;
    logic [15:0] tok_start;
    logic [15:0] tok_len;
    logic [15:0] tok_line;
    logic [15:0] tok_col;
    logic [15:0] line_ctr;
    logic [15:0] col_ctr;
    logic        halted;

    t_result     owed_tokens[$];

    function automatic logic [15:0] sat_bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic char_is_num(input logic [7:0] c);
        return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
    endfunction

    function automatic logic char_is_letter(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_US);
    endfunction

    task automatic lexer_restart();
        scan_state = MODE_IDLE;
        offset_ctr = '0;
        tok_start  = '0;
        tok_len    = '0;
        tok_line   = 16'd1;
        tok_col    = 16'd1;
        line_ctr   = 16'd1;
        col_ctr    = 16'd1;
        halted     = 1'b0;
    endtask

    task automatic owe_token(input t_kind kind, input logic [15:0] start,
                             input logic [15:0] len, input logic [15:0] line,
                             input logic [15:0] col, input logic [7:0] bad,
                             input logic done);
        t_result tok;
        tok.kind  = kind;
        tok.start = start;
        tok.len   = len;
        tok.line  = line;
        tok.col   = col;
        tok.bad   = bad;
        tok.done  = done;
        owed_tokens.push_back(tok);
    endtask

    task automatic open_token(input t_mode mode, input logic [15:0] start,
                              input logic [15:0] len);
        scan_state = mode;
        tok_start  = start;
        tok_len    = len;
        tok_line   = line_ctr;
        tok_col    = col_ctr;
    endtask

    task automatic close_token();
        t_kind kind;
        case (scan_state)
            MODE_INT:   kind = KIND_INT;
            MODE_IDENT: kind = KIND_IDENT;
            MODE_STR:   kind = KIND_STR;
            default:    return;
        endcase
        owe_token(kind, tok_start, tok_len, tok_line, tok_col, 8'h00, 1'b0);
        scan_state = MODE_IDLE;
    endtask

    task automatic lex_byte(input logic [7:0] c, input logic last);
        logic [15:0] byte_col;
        logic        taken;
        logic        newline;
        byte_col = col_ctr;
        taken    = 1'b0;
        newline  = 1'b0;

        if (halted) begin
            if (last) lexer_restart();
            return;
        end

        case (scan_state)
            MODE_STR: begin
                if (c == CH_QUOTE) close_token();
                else tok_len = sat_bump(tok_len);
                taken = 1'b1;
            end
            MODE_INT: begin
                if (char_is_num(c)) begin
                    tok_len = sat_bump(tok_len);
                    taken   = 1'b1;
                end else begin
                    close_token();
                end
            end
            MODE_IDENT: begin
                if (char_is_num(c) || char_is_letter(c)) begin
                    tok_len = sat_bump(tok_len);
                    taken   = 1'b1;
                end else begin
                    close_token();
                end
            end
            default: ;
        endcase

        if (!taken) begin
            if (char_is_num(c)) begin
                open_token(MODE_INT, offset_ctr, 16'd1);
            end else if (char_is_letter(c)) begin
                open_token(MODE_IDENT, offset_ctr, 16'd1);
            end else if (c == CH_QUOTE) begin
                // contents start after the quote, position is the quote's
                open_token(MODE_STR, sat_bump(offset_ctr), 16'd0);
            end else if (c == CH_LSQ) begin
                owe_token(KIND_LSQ, offset_ctr, 16'd1, line_ctr, col_ctr, 8'h00, 1'b0);
            end else if (c == CH_RSQ) begin
                owe_token(KIND_RSQ, offset_ctr, 16'd1, line_ctr, col_ctr, 8'h00, 1'b0);
            end else if (c == CH_COMMA) begin
                owe_token(KIND_COMMA, offset_ctr, 16'd1, line_ctr, col_ctr, 8'h00, 1'b0);
            end else if (c == CH_LF) begin
                newline = 1'b1;
            end else if (c != CH_SP && c != CH_TAB && c != CH_CR) begin
                owe_token(KIND_ERR, offset_ctr, 16'd1, line_ctr, col_ctr, c, 1'b1);
                if (last) begin
                    lexer_restart();
                end else begin
                    halted     = 1'b1;
                    scan_state = MODE_IDLE;
                end
                return;
            end
        end

        offset_ctr = sat_bump(offset_ctr);
        if (newline) begin
            line_ctr = sat_bump(line_ctr);
            col_ctr  = 16'd1;
        end else begin
            col_ctr = sat_bump(col_ctr);
        end

        if (last) begin
            close_token();
            owe_token(KIND_END, offset_ctr, 16'd0, line_ctr, byte_col, 8'h00, 1'b1);
            lexer_restart();
        end
    endtask

    function automatic int field_diff(input string name, input logic [15:0] want,
                                      input logic [15:0] seen);
        if (want !== seen) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            lexer_restart();
            owed_tokens.delete();
            o_fail_count = 0;
        end else begin
            if (i_byte_valid && i_byte_ready) lex_byte(i_byte_data, i_byte_last);
            if (i_token_valid && i_token_ready) begin
                if (owed_tokens.size() == 0) begin
                    $error("token word with none expected: kind %0d offset %0d",
                           i_token_user, i_token_data[15:0]);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = owed_tokens.pop_front();
                    o_fail_count = o_fail_count
                        + field_diff("token_kind", 16'(want.kind), 16'(i_token_user))
                        + field_diff("start_offset", want.start, i_token_data[15:0])
                        + field_diff("token_length", want.len, i_token_data[31:16])
                        + field_diff("line_number", want.line, i_token_data[47:32])
                        + field_diff("column_number", want.col, i_token_data[63:48])
                        + field_diff("bad_byte", 16'(want.bad), 16'(i_token_data[71:64]))
                        + field_diff("stream_done", 16'(want.done), 16'(i_token_last));
                end
            end
        end
        o_tokens_owed = owed_tokens.size();
    end

endmodule

// ===== verif/bracket_config_text_lexer_unit_test.sv =====
// Stimulus and verdict for the bracket config text lexer: directed texts and random
// token streams under varying back pressure, with one long receiver hold-off.
// Depends on bclt_pkg, bracket_config_text_lexer_unit and lexer_token_checker.
`timescale 1ns / 1ps

module bracket_config_text_lexer_unit_test;
    import bclt_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_BYTES   = 135;
    localparam int HOLD_CYCLES   = 60;

    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7E;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;     // data_byte
    logic        s_axis_tlast = 1'b0;      // final_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;             // start_offset, token_length, line_number,
                                           // column_number, bad_byte
    logic [2:0]  m_axis_tuser;             // token_kind
    logic        m_axis_tlast;             // stream_done

    int          fail_count;
    int          tokens_owed;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    logic        hold_request = 1'b0;
    logic        hold_done = 1'b0;
    int          quiet_cycles = 0;
    int          phase_bytes;
    logic [7:0]  text_bytes[$];

    always #5 i_clk = ~i_clk;

    bracket_config_text_lexer_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    lexer_token_checker token_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_byte_valid  (s_axis_tvalid),
        .i_byte_ready  (s_axis_tready),
        .i_byte_data   (s_axis_tdata),
        .i_byte_last   (s_axis_tlast),
        .i_token_valid (m_axis_tvalid),
        .i_token_ready (m_axis_tready),
        .i_token_data  (m_axis_tdata),
        .i_token_user  (m_axis_tuser),
        .i_token_last  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_tokens_owed (tokens_owed)
    );

    // receiver: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request && !hold_done) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end else begin
                m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
                $display("simulation failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_byte(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = c;
        s_axis_tlast  = last;
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
        end
        @(negedge i_clk);
        phase_bytes++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] word_char(input logic first);
        int r;
        r = first ? $urandom_range(52) : $urandom_range(62);
        if (r < 26) return CH_LOWER_A + 8'(r);
        if (r < 52) return CH_UPPER_A + 8'(r - 26);
        if (r < 62 && !first) return CH_DIGIT_0 + 8'(r - 52);
        return CH_US;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(3))
            0:       return CH_SP;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    // mostly well-formed tokens, some random bytes that may abort the text
    task automatic build_text();
        int n_tok;
        int n;
        logic [7:0] c;
        text_bytes.delete();
        n_tok = $urandom_range(1, 12);
        for (int t = 0; t < n_tok; t++) begin
            case ($urandom_range(9))
                0: text_bytes.push_back(CH_LSQ);
                1: text_bytes.push_back(CH_RSQ);
                2: text_bytes.push_back(CH_COMMA);
                3, 4: begin
                    text_bytes.push_back(word_char(1'b1));
                    n = $urandom_range(5);
                    repeat (n) text_bytes.push_back(word_char(1'b0));
                end
                5: begin
                    n = $urandom_range(1, 4);
                    repeat (n) text_bytes.push_back(CH_DIGIT_0 + 8'($urandom_range(9)));
                end
                6, 7: begin
                    text_bytes.push_back(CH_QUOTE);
                    n = $urandom_range(5);
                    repeat (n) begin
                        if ($urandom_range(4) == 0) c = 8'($urandom_range(255));
                        else c = 8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
                        if (c == CH_QUOTE) c = CH_LF;
                        text_bytes.push_back(c);
                    end
                    // leave the last string open now and then
                    if (t != n_tok - 1 || $urandom_range(5) != 0)
                        text_bytes.push_back(CH_QUOTE);
                end
                8: begin
                    n = $urandom_range(1, 2);
                    repeat (n) text_bytes.push_back(blank_char());
                end
                default: begin
                    if ($urandom_range(9) < 3) text_bytes.push_back(8'($urandom_range(255)));
                    else text_bytes.push_back(CH_SP);
                end
            endcase
            if ($urandom_range(1) == 0) text_bytes.push_back(blank_char());
        end
    endtask

    task automatic send_random_texts();
        phase_bytes = 0;
        while (phase_bytes < PHASE_BYTES) begin
            build_text();
            foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 15;
        recv_idle_pct = 71;
        // punctuation, int then ident, LF in a string, final LF
        send_text("[9a_,\"q\n\"]\n");
        send_text("\"ab");          // string open at the final byte
        send_text("Z\t1");          // final byte inside an integer
        send_text(" \r");           // only blanks: end token alone
        // pending ident flushed before the error, rest ignored
        send_byte(8'h78, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(CH_RSQ, 1'b1);
        send_byte(8'hFF, 1'b1);     // error on the final byte
        send_random_texts();

        send_idle_pct = 71;
        recv_idle_pct = 15;
        send_random_texts();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1'b1;
        send_random_texts();
        s_axis_tvalid = 1'b0;

        while (tokens_owed != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== bracket_config_text_lexer_unit.f =====
src/bclt_pkg.sv
src/bclt_front.sv
src/bclt_queue.sv
src/bclt_back.sv
src/bracket_config_text_lexer_unit.sv
src/bclt_checker.sv
verif/lexer_token_checker.sv
verif/bracket_config_text_lexer_unit_test.sv
